// ===== hdl/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PIX_W      = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 16;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 16;
  localparam int LS_ADDR_W  = $clog2(MAX_WIDTH);
  localparam int LS_DATA_W  = 2 * PIX_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd512;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 16'd512;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [COL_W-1:0] out_column;
    logic [ROW_W-1:0] out_row;
    logic             last_of_run;
  } res_t;

  // position and flags of one pixel as it moves down the pipeline
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] pixel;
    logic             has_med;
    logic             has_pass;
  } item_t;

  // up to two results written into the output queue in one cycle
  typedef struct packed {
    logic en0;
    logic en1;
    res_t d0;
    res_t d1;
  } push_t;

endpackage

// ===== hdl/mf3_line_store.sv =====
// ----------------------------------------------------------------------------
// mf3_line_store
// Storage of the two previous rows, one entry per column holding both pixels.
// ----------------------------------------------------------------------------
module mf3_line_store (
  input  logic                          clk,
  input  logic [mf3_pkg::LS_ADDR_W-1:0] rd_addr,
  output logic [mf3_pkg::LS_DATA_W-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [mf3_pkg::LS_ADDR_W-1:0] wr_addr,
  input  logic [mf3_pkg::LS_DATA_W-1:0] wr_data
);
  import mf3_pkg::*;

  logic [LS_DATA_W-1:0] mem [MAX_WIDTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/mf3_median.sv =====
// ----------------------------------------------------------------------------
// mf3_median
// 3x3 window of sorted columns and a two-stage median of nine.
// ----------------------------------------------------------------------------
module mf3_median (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      col_valid,
  input  mf3_pkg::item_t            col_item,
  input  logic [mf3_pkg::PIX_W-1:0] col_up,
  input  logic [mf3_pkg::PIX_W-1:0] col_mid,
  output logic                      med_valid,
  output mf3_pkg::item_t            med_item,
  output logic [mf3_pkg::PIX_W-1:0] median
);
  import mf3_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] hi;
  } col_t;

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(input logic [PIX_W-1:0] a,
                                 input logic [PIX_W-1:0] b,
                                 input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] x, y, z, t;
    col_t s;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    s.lo = x;
    s.md = y;
    s.hi = z;
    return s;
  endfunction

  col_t             win [3];
  logic             s2_valid;
  item_t            s2_item;
  logic [PIX_W-1:0] s3_lo;
  logic [PIX_W-1:0] s3_md;
  logic [PIX_W-1:0] s3_hi;
  col_t             new_col;

  assign new_col = sort3(col_up, col_mid, col_item.pixel);

  // window holds each column already sorted, oldest in slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      win[0]    <= '0;
      win[1]    <= '0;
      win[2]    <= '0;
      s2_valid  <= 1'b0;
      med_valid <= 1'b0;
    end else begin
      if (col_valid) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= new_col;
      end
      s2_valid  <= col_valid;
      med_valid <= s2_valid;
    end
  end

  // median of nine = med3(max of lows, median of middles, min of highs)
  always_ff @(posedge clk) begin
    s2_item  <= col_item;
    med_item <= s2_item;
    s3_lo    <= max2(max2(win[0].lo, win[1].lo), win[2].lo);
    s3_md    <= med3(win[0].md, win[1].md, win[2].md);
    s3_hi    <= min2(min2(win[0].hi, win[1].hi), win[2].hi);
  end

  assign median = med3(s3_lo, s3_md, s3_hi);

endmodule

// ===== hdl/mf3_out_fifo.sv =====
// ----------------------------------------------------------------------------
// mf3_out_fifo
// Result queue taking up to two results per cycle and giving one per cycle while res_ready is high.
// ----------------------------------------------------------------------------
module mf3_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  mf3_pkg::push_t                 push,
  output logic                           res_valid,
  input  logic                           res_ready,
  output mf3_pkg::res_t                  res_data,
  output logic [mf3_pkg::FIFO_CNT_W-1:0] count
);
  import mf3_pkg::*;

  res_t                  slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;
  logic [1:0]            n_push;

  assign res_valid = (count != '0);
  assign res_data  = slots[rd_ptr];
  assign pop       = res_valid && res_ready;
  assign n_push    = {1'b0, push.en0} + {1'b0, push.en1};

  always_ff @(posedge clk) begin
    if (push.en0) begin
      slots[wr_ptr] <= push.d0;
    end
    if (push.en1) begin
      slots[wr_ptr + FIFO_PTR_W'(1)] <= push.d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(n_push);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      count  <= count + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
    end
  end

endmodule

// ===== hdl/median_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter over a raster stream of 8-bit grey pixels.
//
// Pixels enter on pix_valid/pix_ready in raster order; frame_start marks the
// pixel at column 0, row 0. Frame width and height must be written on the
// cfg port only while the block is idle; the block does not enforce this.
// Each pixel causes zero, one or two results on res_valid/res_ready: the
// median of the pixel up and to the left (when that one is interior), then
// the pixel itself when it lies on the frame border. last_of_run marks the
// final result of a transaction. Throughput: one pixel per clock while
// pix_ready is high, set by the single read-modify-write of the line store
// per pixel with forwarding for a repeated column. Each accepted pixel
// reserves room for its results in a 16-entry queue; pix_ready falls while
// more than 14 entries are reserved, so a stalled receiver holds the input
// after a few pixels and nothing is lost. Reset clears the position to
// (0,0), the window to zero and both registers to 512; line store contents
// are undefined until written.
// ----------------------------------------------------------------------------
module median_filter_3x3 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  mf3_pkg::pix_t                  pix_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output mf3_pkg::res_t                  res_data,
  input  logic                           cfg_write,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mf3_pkg::*;

  localparam logic [FIFO_CNT_W-1:0] CREDIT_MAX   = FIFO_CNT_W'(FIFO_DEPTH);
  localparam logic [FIFO_CNT_W-1:0] CREDIT_LIMIT = FIFO_CNT_W'(FIFO_DEPTH - 2);

  logic [WIDTH_W-1:0]    frame_width;
  logic [HEIGHT_W-1:0]   frame_height;
  logic [COL_W-1:0]      col_count;
  logic [ROW_W-1:0]      row_count;
  logic [FIFO_CNT_W-1:0] pending;

  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [COL_W-1:0]    c0;
  logic [ROW_W-1:0]    r0;
  logic                wrap_in;
  logic [ROW_W:0]      r1x;
  logic [COL_W-1:0]    c1;
  logic [ROW_W-1:0]    r1;
  logic [WIDTH_W-1:0]  c_inc;
  logic [ROW_W:0]      r_inc;
  logic [COL_W-1:0]    col_next;
  logic [ROW_W-1:0]    row_next;
  item_t               acc_item;
  logic                accept;
  logic [1:0]          n_acc;
  logic                pop;

  logic                 s1_valid;
  item_t                s1_item;
  logic                 s1_fwd;
  logic [LS_DATA_W-1:0] fwd_data;
  logic [LS_DATA_W-1:0] ls_rd_data;
  logic [LS_DATA_W-1:0] s1_entry;
  logic [PIX_W-1:0]     s1_up;
  logic [PIX_W-1:0]     s1_mid;

  logic                  s3_valid;
  item_t                 s3_item;
  logic [PIX_W-1:0]      s3_median;
  res_t                  med_res;
  res_t                  pass_res;
  push_t                 push;
  logic [FIFO_CNT_W-1:0] fifo_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // position of the incoming pixel, with the frame limits clamped
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (frame_width > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    h_eff = (frame_height == '0) ? HEIGHT_W'(1) : frame_height;

    c0      = pix_data.frame_start ? '0 : col_count;
    r0      = pix_data.frame_start ? '0 : row_count;
    wrap_in = ({1'b0, c0} >= w_eff);
    c1      = wrap_in ? '0 : c0;
    r1x     = wrap_in ? ({1'b0, r0} + (ROW_W+1)'(1)) : {1'b0, r0};
    r1      = (r1x >= {1'b0, h_eff}) ? '0 : r1x[ROW_W-1:0];

    acc_item.col      = c1;
    acc_item.row      = r1;
    acc_item.pixel    = pix_data.pixel_in;
    acc_item.has_med  = (c1 >= COL_W'(2)) && (r1 >= ROW_W'(2));
    acc_item.has_pass = (c1 == '0) || (r1 == '0) ||
                        ({1'b0, c1} == w_eff - WIDTH_W'(1)) ||
                        (r1 == h_eff - HEIGHT_W'(1));

    c_inc = {1'b0, c1} + WIDTH_W'(1);
    r_inc = {1'b0, r1} + (ROW_W+1)'(1);
    if (c_inc >= w_eff) begin
      col_next = '0;
      row_next = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_next = c_inc[COL_W-1:0];
      row_next = r1;
    end
  end

  assign accept    = pix_valid && pix_ready;
  assign n_acc     = {1'b0, acc_item.has_med} + {1'b0, acc_item.has_pass};
  assign pop       = res_valid && res_ready;
  // queue slots reserved by pixels in flight plus results still queued
  assign pix_ready = (pending <= CREDIT_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      pending   <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept) begin
        col_count <= col_next;
        row_count <= row_next;
      end
      pending  <= pending + FIFO_CNT_W'(accept ? n_acc : 2'd0) - FIFO_CNT_W'(pop);
      s1_valid <= accept;
    end
  end

  // the previous pixel writes its column back at this edge, so the memory
  // read of the same column is stale and the written value is forwarded
  always_ff @(posedge clk) begin
    s1_item  <= acc_item;
    s1_fwd   <= s1_valid && (s1_item.col == c1);
    fwd_data <= {s1_mid, s1_item.pixel};
  end

  mf3_line_store u_line_store (
    .clk     (clk),
    .rd_addr (c1[LS_ADDR_W-1:0]),
    .rd_data (ls_rd_data),
    .wr_en   (s1_valid),
    .wr_addr (s1_item.col[LS_ADDR_W-1:0]),
    .wr_data ({s1_mid, s1_item.pixel})
  );

  assign s1_entry = s1_fwd ? fwd_data : ls_rd_data;
  assign s1_up    = s1_entry[LS_DATA_W-1:PIX_W];
  assign s1_mid   = s1_entry[PIX_W-1:0];

  mf3_median u_median (
    .clk       (clk),
    .rst       (rst),
    .col_valid (s1_valid),
    .col_item  (s1_item),
    .col_up    (s1_up),
    .col_mid   (s1_mid),
    .med_valid (s3_valid),
    .med_item  (s3_item),
    .median    (s3_median)
  );

  always_comb begin
    med_res.pixel_out   = s3_median;
    med_res.out_column  = s3_item.col - COL_W'(1);
    med_res.out_row     = s3_item.row - ROW_W'(1);
    med_res.last_of_run = !s3_item.has_pass;

    pass_res.pixel_out   = s3_item.pixel;
    pass_res.out_column  = s3_item.col;
    pass_res.out_row     = s3_item.row;
    pass_res.last_of_run = 1'b1;

    push.en0 = s3_valid && (s3_item.has_med || s3_item.has_pass);
    push.en1 = s3_valid && s3_item.has_med && s3_item.has_pass;
    push.d0  = s3_item.has_med ? med_res : pass_res;
    push.d1  = pass_res;
  end

  mf3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .count     (fifo_count)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= CREDIT_MAX)
    else $error("reserved result slots exceed queue depth");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= pending)
    else $error("queued results exceed reserved slots");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    push.en0 |-> (int'(fifo_count) + int'(push.en0) + int'(push.en1) <= FIFO_DEPTH))
    else $error("result pushed into a full queue");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> $past(s1_valid))
    else $error("forwarding without a preceding write");

endmodule
